@@ rtl/prfu_pkg.sv @@
package prfu_pkg;

    localparam int CoordW = 24;
    localparam int ColorW = 32;
    localparam int RadW   = 23;
    localparam int LimW   = RadW + 2;
    localparam int SumW   = 2 * CoordW;
    localparam int RootW  = SumW / 2;
    localparam int TW     = 17;
    localparam int RemW   = RootW + 2;

    localparam logic [RadW-1:0] RadiusReset = RadW'(32768);
    localparam logic [TW-1:0]   TOne        = TW'(65536);
    localparam logic [25:0]     RoundHalf   = 26'd32768;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
        logic [ColorW-1:0]        sc;
        logic [ColorW-1:0]        ec;
        logic                     alive;
    } t_side;

endpackage

@@ rtl/particle_radial_fade_update.sv @@
// channel | dir | fields (lsb first)
// s       | in  | tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, start_color, end_color
//         |     | tuser: alive_in
// m       | out | tdata: new_pos_x, new_pos_y, new_pos_z, blend_color; tuser: alive_out
// cfg     | in  | wdata: radius
// One item per cycle while the m side is not stalled; 3 front stages, 24 root stages
// (one bit each), 18 divider stages, 2 blend stages incl. output register.
// Reset clears valid bits only; radius returns to 0.5.
// A stall on the m side freezes the whole pipeline; o_s_tready drops with it.
module particle_radial_fade_update (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [207:0]                 i_s_tdata,  // pos_x,pos_y,pos_z,vel_x,vel_y,vel_z,sc,ec
    input  logic                         i_s_tuser,  // alive_in
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [103:0]                 o_m_tdata,  // new_pos_x,new_pos_y,new_pos_z,blend_color
    output logic                         o_m_tuser,  // alive_out
    input  logic                         i_cfg_we,
    input  logic [prfu_pkg::RadW-1:0]    i_cfg_wdata
);
    import prfu_pkg::*;

    logic [RadW-1:0]   r_rad;
    logic [LimW-1:0]   c_lim;
    logic              c_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad <= RadiusReset;
        end else if (i_cfg_we) begin
            r_rad <= i_cfg_wdata;
        end
    end
    assign c_lim    = {r_rad, 2'b00};
    assign c_en     = !o_m_tvalid || i_m_tready;
    assign o_s_tready = c_en;

    function automatic logic signed [CoordW-1:0] sat_add(
        input logic signed [CoordW-1:0] a,
        input logic signed [CoordW-1:0] b
    );
        logic signed [CoordW:0] s;
        s = {a[CoordW-1], a} + {b[CoordW-1], b};
        if (s[CoordW] != s[CoordW-1]) begin
            sat_add = s[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
        end else begin
            sat_add = s[CoordW-1:0];
        end
    endfunction

    function automatic logic [CoordW-1:0] mag(input logic signed [CoordW-1:0] v);
        mag = v[CoordW-1] ? (~v + 1'b1) : v;
    endfunction

    // stage 1: saturating position update
    logic  r1_v;
    t_side r1_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (c_en) begin
            r1_v <= i_s_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r1_side.x     <= sat_add(i_s_tdata[23:0], i_s_tdata[95:72]);
            r1_side.y     <= sat_add(i_s_tdata[47:24], i_s_tdata[119:96]);
            r1_side.z     <= sat_add(i_s_tdata[71:48], i_s_tdata[143:120]);
            r1_side.sc    <= i_s_tdata[175:144];
            r1_side.ec    <= i_s_tdata[207:176];
            r1_side.alive <= i_s_tuser;
        end
    end

    // stage 2: squares and limit squared
    logic                r2_v;
    logic [SumW-1:0]     r2_sq [0:2];
    logic [2*LimW-1:0]   r2_limsq;
    t_side               r2_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (c_en) begin
            r2_v <= r1_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r2_sq[0] <= mag(r1_side.x) * mag(r1_side.x);
            r2_sq[1] <= mag(r1_side.y) * mag(r1_side.y);
            r2_sq[2] <= mag(r1_side.z) * mag(r1_side.z);
            r2_limsq <= c_lim * c_lim;
            r2_side  <= r1_side;
        end
    end

    // stage 3: sum of squares and exact death test
    logic [2*LimW-1:0] c_sum;
    t_side             c_side3;
    logic              r3_v;
    logic [SumW-1:0]   r3_sum;
    t_side             r3_side;
    assign c_sum = (2*LimW)'(r2_sq[0]) + (2*LimW)'(r2_sq[1]) + (2*LimW)'(r2_sq[2]);
    always_comb begin
        c_side3       = r2_side;
        c_side3.alive = r2_side.alive && (c_sum <= r2_limsq);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (c_en) begin
            r3_v <= r2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r3_sum  <= c_sum[SumW-1:0];
            r3_side <= c_side3;
        end
    end

    logic              w_root_v;
    logic [RootW-1:0]  w_root;
    t_side             w_root_side;
    logic              w_t_v;
    logic [TW-1:0]     w_t;
    t_side             w_t_side;
    logic [ColorW-1:0] w_color;
    t_side             w_out_side;

    prfu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (r3_v),
        .i_sum   (r3_sum),
        .i_side  (r3_side),
        .o_valid (w_root_v),
        .o_root  (w_root),
        .o_side  (w_root_side)
    );

    prfu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (w_root_v),
        .i_root  (w_root),
        .i_lim   (c_lim),
        .i_side  (w_root_side),
        .o_valid (w_t_v),
        .o_t     (w_t),
        .o_side  (w_t_side)
    );

    prfu_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (w_t_v),
        .i_t     (w_t),
        .i_side  (w_t_side),
        .o_valid (o_m_tvalid),
        .o_color (w_color),
        .o_side  (w_out_side)
    );

    assign o_m_tdata = {w_color, w_out_side.z, w_out_side.y, w_out_side.x};
    assign o_m_tuser = w_out_side.alive;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |=> $stable(r1_v) && $stable(w_t_v))
        else $error("pipeline moved during stall");

    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_t_v |-> w_t <= TOne)
        else $error("blend factor above one");

    a_alive_within: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_v && w_root_side.alive |-> LimW'(w_root) <= c_lim)
        else $error("live particle beyond limit");

endmodule

@@ rtl/prfu_sqrt.sv @@
module prfu_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [prfu_pkg::SumW-1:0]   i_sum,
    input  prfu_pkg::t_side             i_side,
    output logic                        o_valid,
    output logic [prfu_pkg::RootW-1:0]  o_root,
    output prfu_pkg::t_side             o_side
);
    import prfu_pkg::*;

    logic              w_v    [0:RootW];
    logic [RemW-1:0]   w_rem  [0:RootW];
    logic [RootW-1:0]  w_root [0:RootW];
    logic [SumW-1:0]   w_s    [0:RootW];
    t_side             w_side [0:RootW];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_s[0]    = i_sum;
    assign w_side[0] = i_side;

    // one root bit per stage
    for (genvar i = 0; i < RootW; i++) begin : g_stage
        logic [RemW-1:0]  c_rem_sh;
        logic [RemW-1:0]  c_trial;
        logic             c_ge;
        logic             r_v;
        logic [RemW-1:0]  r_rem;
        logic [RootW-1:0] r_root;
        logic [SumW-1:0]  r_s;
        t_side            r_side;

        assign c_rem_sh = {w_rem[i][RemW-3:0], w_s[i][SumW-1 -: 2]};
        assign c_trial  = {w_root[i], 2'b01};
        assign c_ge     = c_rem_sh >= c_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= c_ge ? c_rem_sh - c_trial : c_rem_sh;
                r_root <= {w_root[i][RootW-2:0], c_ge};
                r_s    <= {w_s[i][SumW-3:0], 2'b00};
                r_side <= w_side[i];
            end
        end

        assign w_v[i+1]    = r_v;
        assign w_rem[i+1]  = r_rem;
        assign w_root[i+1] = r_root;
        assign w_s[i+1]    = r_s;
        assign w_side[i+1] = r_side;
    end

    assign o_valid = w_v[RootW];
    assign o_root  = w_root[RootW];
    assign o_side  = w_side[RootW];

endmodule

@@ rtl/prfu_div.sv @@
module prfu_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [prfu_pkg::RootW-1:0]  i_root,
    input  logic [prfu_pkg::LimW-1:0]   i_lim,
    input  prfu_pkg::t_side             i_side,
    output logic                        o_valid,
    output logic [prfu_pkg::TW-1:0]     o_t,
    output prfu_pkg::t_side             o_side
);
    import prfu_pkg::*;

    logic            r0_v;
    logic            r0_sat;
    logic            r0_d0;
    logic [RemW-1:0] r0_rem;
    t_side           r0_side;

    // root >= 2*lim means quotient above one: saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_sat  <= {2'b00, i_root} >= {i_lim, 1'b0};
            r0_d0   <= i_root[0];
            r0_rem  <= RemW'(i_root[RootW-1:1]);
            r0_side <= i_side;
        end
    end

    logic            w_v    [0:TW];
    logic            w_sat  [0:TW];
    logic [RemW-1:0] w_rem  [0:TW];
    logic [TW-1:0]   w_q    [0:TW];
    t_side           w_side [0:TW];

    assign w_v[0]    = r0_v;
    assign w_sat[0]  = r0_sat;
    assign w_rem[0]  = r0_rem;
    assign w_q[0]    = '0;
    assign w_side[0] = r0_side;

    for (genvar i = 0; i < TW; i++) begin : g_stage
        logic            c_bit;
        logic [RemW-1:0] c_rem_sh;
        logic            c_ge;
        logic            r_v;
        logic            r_sat;
        logic [RemW-1:0] r_rem;
        logic [TW-1:0]   r_q;
        t_side           r_side;

        assign c_bit    = (i == 0) ? r0_d0 : 1'b0;
        assign c_rem_sh = {w_rem[i][RemW-2:0], c_bit};
        assign c_ge     = c_rem_sh >= RemW'(i_lim);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat  <= w_sat[i];
                r_rem  <= c_ge ? c_rem_sh - RemW'(i_lim) : c_rem_sh;
                r_q    <= {w_q[i][TW-2:0], c_ge};
                r_side <= w_side[i];
            end
        end

        assign w_v[i+1]    = r_v;
        assign w_sat[i+1]  = r_sat;
        assign w_rem[i+1]  = r_rem;
        assign w_q[i+1]    = r_q;
        assign w_side[i+1] = r_side;
    end

    assign o_valid = w_v[TW];
    assign o_t     = (w_sat[TW] || w_q[TW] > TOne) ? TOne : w_q[TW];
    assign o_side  = w_side[TW];

endmodule

@@ rtl/prfu_blend.sv @@
module prfu_blend (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [prfu_pkg::TW-1:0]     i_t,
    input  prfu_pkg::t_side             i_side,
    output logic                        o_valid,
    output logic [prfu_pkg::ColorW-1:0] o_color,
    output prfu_pkg::t_side             o_side
);
    import prfu_pkg::*;

    logic          r1_v;
    logic [24:0]   r1_pa [0:3];
    logic [24:0]   r1_pb [0:3];
    t_side         r1_side;
    logic          r2_v;
    logic [ColorW-1:0] r2_color;
    t_side         r2_side;
    logic [TW-1:0] c_tinv;
    logic [ColorW-1:0] c_color;

    assign c_tinv = TOne - i_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_ch
        logic [25:0] c_acc;

        assign c_acc = {1'b0, r1_pa[c]} + {1'b0, r1_pb[c]} + RoundHalf;
        assign c_color[8*c +: 8] = c_acc[23:16];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r1_pa[c] <= c_tinv * i_side.sc[8*c +: 8];
                r1_pb[c] <= i_t * i_side.ec[8*c +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side  <= i_side;
            r2_color <= c_color;
            r2_side  <= r1_side;
        end
    end

    assign o_valid = r2_v;
    assign o_color = r2_color;
    assign o_side  = r2_side;

endmodule
